@@ rtl/core/terrain_quad_vertex_generator_defines.svh @@
// Assertion macros for the terrain quad vertex generator.
// Used by the port-level checker only.
`ifndef TERRAIN_QUAD_VERTEX_GENERATOR_DEFINES_SVH
`define TERRAIN_QUAD_VERTEX_GENERATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TQV_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tqv check failed");
// Next-cycle implication.
`define TQV_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tqv check failed");
`endif

@@ rtl/core/tqvg_pkg.sv @@
// Package for the terrain quad vertex generator: types and constants.
// No dependencies.
`timescale 1ns / 1ps
package tqvg_pkg;
  localparam logic [1:0] SideTop   = 2'd0;
  localparam logic [1:0] SideFront = 2'd1;
  localparam logic [1:0] SideRight = 2'd2;

  localparam logic [1:0] RegGridScale = 2'd0;
  localparam logic [1:0] RegAtlasCols = 2'd1;
  localparam logic [1:0] RegAtlasRows = 2'd2;

  typedef enum logic [4:0] {
    StIdle,
    StPos,
    StEdge,
    StCrossA,
    StCrossB,
    StCrossC,
    StMag,
    StShift,
    StSq,
    StSqrtGo,
    StSqrtWait,
    StNrmGo,
    StNrmWait,
    StIdGo,
    StIdWait,
    StAtGo,
    StAtWait,
    StEmit
  } seq_state_e;

  // Request to the shared divider / root unit.
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [47:0] rem;
  } div_rsp_t;
endpackage

@@ rtl/core/terrain_quad_vertex_generator.sv @@
// Terrain quad vertex generator top level: sequencer, datapath, config port.
// Depends on tqvg_pkg and tqvg_divsqrt.
//
// Usage: one surface is transferred on the input channel (valid_i, stall_o);
// four vertices follow on the output channel (valid_o, stall_i), last_o on
// the fourth. APB registers: 0x0 grid_scale, 0x4 atlas_columns, 0x8 atlas_rows.
// Write them only while the block is idle.
// The sequence forms the positions, the edges and the cross product, then
// shifts the cross product down until it fits; it then runs one square root,
// three normal divides, one id divide and four atlas divides on the single
// shared bit-serial unit. A zero-length normal does not wait for the three
// normal divides. Vertices then follow one per cycle unless stalled. A new
// surface is taken only once the last vertex of the previous one has gone.
// stall_o is high while a surface is in work or its vertices are being
// delivered.
// Reset clears the quad counter, the sequencer and sets register defaults.
// A stalled vertex holds on the output until taken.
//
`timescale 1ns / 1ps
module terrain_quad_vertex_generator import tqvg_pkg::*; #(
  parameter int MAX_QUADS = 16384,
  parameter int GRID_MAX  = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [9:0]         cell_x_i,
  input  logic [9:0]         cell_y_i,
  input  logic [1:0]         side_i,
  input  logic signed [23:0] corner_height_0_i,
  input  logic signed [23:0] corner_height_1_i,
  input  logic signed [23:0] corner_height_2_i,
  input  logic signed [23:0] corner_height_3_i,
  input  logic signed [23:0] neighbor_height_a_i,
  input  logic signed [23:0] neighbor_height_b_i,
  input  logic [15:0]        lightmap_id_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [15:0]        vertex_index_o,
  output logic signed [27:0] pos_x_o,
  output logic signed [27:0] pos_y_o,
  output logic signed [27:0] pos_z_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic [15:0]        atlas_u_o,
  output logic [15:0]        atlas_v_o,
  output logic               last_o
);
  localparam int QW = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1;

  // configuration
  logic [15:0] scale_q, cols_q, rows_q;
  logic        wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 16'd2560; cols_q <= 16'd1; rows_q <= 16'd1;
    end else if (wr) begin
      unique case (paddr[3:2])
        RegGridScale: scale_q <= pwdata[15:0];
        RegAtlasCols: cols_q  <= pwdata[15:0];
        RegAtlasRows: rows_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      RegGridScale: prdata = {16'd0, scale_q};
      RegAtlasCols: prdata = {16'd0, cols_q};
      RegAtlasRows: prdata = {16'd0, rows_q};
      default:      prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  seq_state_e st_q, st_d;
  logic [QW-1:0] qc_q;
  logic [1:0]    k_q;
  logic [1:0]    j_q;   // component / coordinate sub-step
  logic [9:0]    cx_q, cy_q;
  logic [1:0]    side_q;
  logic signed [23:0] h_q [6];
  logic [15:0]   id_q;
  logic signed [27:0] px_q [4];
  logic signed [27:0] py_q [4];
  logic signed [27:0] pz_q [4];
  logic signed [28:0] a_q [3];
  logic signed [28:0] b_q [3];
  logic signed [63:0] prod_q, n_q [3];
  logic [63:0]   mag_q [3];
  logic          neg_q [3];
  logic [63:0]   sum_q;
  logic [31:0]   len_q;
  logic signed [15:0] nrm_q [3];
  logic [15:0]   tr_q, tc_q;
  logic [15:0]   at_q [4];

  div_req_t req;
  div_rsp_t rsp;
  tqvg_divsqrt u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  logic accept, emit;
  assign accept = (st_q == StIdle) && valid_i;
  assign stall_o = (st_q != StIdle);
  assign valid_o = (st_q == StEmit);
  assign emit = valid_o && !stall_i;

  logic [15:0] rows_e, cols_e;
  assign rows_e = (rows_q == 16'd0) ? 16'd1 : rows_q;
  assign cols_e = (cols_q == 16'd0) ? 16'd1 : cols_q;

  // shared 29x29 multiply operands
  logic signed [28:0] ma, mb;
  always_comb begin
    unique case (j_q)
      2'd0: begin ma = a_q[1]; mb = b_q[2]; end
      2'd1: begin ma = a_q[2]; mb = b_q[0]; end
      default: begin ma = a_q[0]; mb = b_q[1]; end
    endcase
    if (st_q == StCrossB) begin
      unique case (j_q)
        2'd0: begin ma = a_q[2]; mb = b_q[1]; end
        2'd1: begin ma = a_q[0]; mb = b_q[2]; end
        default: begin ma = a_q[1]; mb = b_q[0]; end
      endcase
    end
  end

  logic [63:0] mx;
  assign mx = (mag_q[0] > mag_q[1]) ? ((mag_q[0] > mag_q[2]) ? mag_q[0] : mag_q[2])
                                    : ((mag_q[1] > mag_q[2]) ? mag_q[1] : mag_q[2]);

  // atlas: tile, frac, n per step j
  logic [15:0] at_tile, at_n;
  logic [3:0]  at_f;
  assign at_tile = j_q[1] ? tc_q : tr_q;
  assign at_n    = j_q[1] ? cols_e : rows_e;
  assign at_f    = j_q[0] ? 4'd9 : 4'd1;
  logic [20:0] at_den;
  logic [20:0] at_tnum;
  assign at_den  = {5'd0, at_n} * 21'd10;
  assign at_tnum = {5'd0, at_tile} * 21'd10 + {17'd0, at_f};

  always_comb begin
    st_d = st_q;
    req = '0;
    unique case (st_q)
      StIdle:  if (accept) st_d = StPos;
      StPos:   st_d = StEdge;
      StEdge:  st_d = StCrossA;
      StCrossA: st_d = StCrossB;
      StCrossB: st_d = StCrossC;
      StCrossC: st_d = (j_q == 2'd2) ? StMag : StCrossA;
      StMag:   st_d = StShift;
      StShift: if (mx < 64'h4000_0000) st_d = StSq;
      StSq:    if (j_q == 2'd2) st_d = StSqrtGo;
      StSqrtGo: begin
        req.start = 1'b1; req.is_sqrt = 1'b1; req.num = sum_q;
        st_d = StSqrtWait;
      end
      StSqrtWait: if (rsp.done) st_d = StNrmGo;
      StNrmGo: begin
        req.start = 1'b1;
        req.num = {1'b0, mag_q[j_q][47:0], 15'd0} + {32'd0, len_q};
        req.den = {15'd0, len_q, 1'b0};
        if (len_q == 32'd0) st_d = (j_q == 2'd2) ? StIdGo : StNrmGo;
        else st_d = StNrmWait;
      end
      StNrmWait: if (rsp.done) st_d = (j_q == 2'd2) ? StIdGo : StNrmGo;
      StIdGo: begin
        req.start = 1'b1; req.num = {48'd0, id_q}; req.den = {32'd0, rows_e};
        st_d = StIdWait;
      end
      StIdWait: if (rsp.done) st_d = StAtGo;
      StAtGo: begin
        req.start = 1'b1;
        req.num = {27'd0, at_tnum, 16'd0} + {44'd0, at_den[20:1]};
        req.den = {27'd0, at_den};
        st_d = StAtWait;
      end
      StAtWait: if (rsp.done) st_d = (j_q == 2'd3) ? StEmit : StAtGo;
      StEmit:  if (emit && k_q == 2'd3) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // j_q wraps to zero at the end of each loop, so every loop starts at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; qc_q <= '0; k_q <= '0; j_q <= '0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        StCrossC: j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
        StSq:     j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
        StNrmGo:  if (len_q == 32'd0) j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
        StNrmWait: if (rsp.done) j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
        StAtWait: if (rsp.done) j_q <= j_q + 2'd1;
        default: ;
      endcase
      if (emit) begin
        k_q <= k_q + 2'd1;
        if (k_q == 2'd3) qc_q <= (qc_q == QW'(MAX_QUADS - 1)) ? '0 : qc_q + 1'b1;
      end
    end
  end

  logic [9:0] cxc, cyc;
  logic [27:0] x0, x1, z0, z1;
  assign cxc = (cx_q >= 10'(GRID_MAX - 1)) ? 10'(GRID_MAX - 1) : cx_q;
  assign cyc = (cy_q >= 10'(GRID_MAX - 1)) ? 10'(GRID_MAX - 1) : cy_q;
  assign x0 = 28'({cxc} * scale_q);
  assign x1 = 28'({1'b0, cxc} + 11'd1) * 28'(scale_q);
  assign z0 = 28'({cyc} * scale_q);
  assign z1 = 28'({1'b0, cyc} + 11'd1) * 28'(scale_q);

  logic signed [27:0] hx [6];
  always_comb for (int i = 0; i < 6; i++) hx[i] = 28'(h_q[i]);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q <= cell_x_i; cy_q <= cell_y_i; side_q <= side_i; id_q <= lightmap_id_i;
      h_q[0] <= corner_height_0_i; h_q[1] <= corner_height_1_i;
      h_q[2] <= corner_height_2_i; h_q[3] <= corner_height_3_i;
      h_q[4] <= neighbor_height_a_i; h_q[5] <= neighbor_height_b_i;
    end
    unique case (st_q)
      StPos: begin
        if (side_q == SideFront) begin
          px_q <= '{x0, x1, x0, x1}; pz_q <= '{z1, z1, z1, z1};
          py_q <= '{hx[2], hx[3], hx[4], hx[5]};
        end else if (side_q == SideRight) begin
          px_q <= '{x1, x1, x1, x1}; pz_q <= '{z1, z0, z1, z0};
          py_q <= '{hx[3], hx[1], hx[4], hx[5]};
        end else begin
          px_q <= '{x0, x1, x0, x1}; pz_q <= '{z0, z0, z1, z1};
          py_q <= '{hx[0], hx[1], hx[2], hx[3]};
        end
      end
      StEdge: begin
        a_q[0] <= 29'(px_q[1]) - 29'(px_q[0]); b_q[0] <= 29'(px_q[2]) - 29'(px_q[0]);
        a_q[1] <= 29'(py_q[1]) - 29'(py_q[0]); b_q[1] <= 29'(py_q[2]) - 29'(py_q[0]);
        a_q[2] <= 29'(pz_q[1]) - 29'(pz_q[0]); b_q[2] <= 29'(pz_q[2]) - 29'(pz_q[0]);
      end
      StCrossA: prod_q <= 64'(ma * mb);
      StCrossB: n_q[j_q] <= prod_q - 64'(ma * mb);
      StMag: for (int i = 0; i < 3; i++) begin
        neg_q[i] <= n_q[i][63];
        mag_q[i] <= n_q[i][63] ? 64'(-n_q[i]) : n_q[i];
      end
      StShift: if (mx >= 64'h4000_0000)
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
      StSq: begin
        if (j_q == 2'd0) sum_q <= 64'(mag_q[0][29:0] * mag_q[0][29:0]);
        else sum_q <= sum_q + 64'(mag_q[j_q][29:0] * mag_q[j_q][29:0]);
      end
      StSqrtWait: if (rsp.done) len_q <= rsp.quo[31:0];
      StNrmGo: if (len_q == 32'd0) nrm_q[j_q] <= '0;
      StNrmWait: if (rsp.done)
        nrm_q[j_q] <= neg_q[j_q] ? -16'(rsp.quo[15:0]) : 16'(rsp.quo[15:0]);
      StIdWait: if (rsp.done) begin
        tc_q <= rsp.quo[15:0]; tr_q <= rsp.rem[15:0];
      end
      StAtWait: if (rsp.done)
        at_q[j_q] <= (rsp.quo > 64'd65535) ? 16'hFFFF : rsp.quo[15:0];
      default: ;
    endcase
  end

  assign vertex_index_o = 16'({qc_q, k_q});
  assign pos_x_o = px_q[k_q];
  assign pos_y_o = py_q[k_q];
  assign pos_z_o = pz_q[k_q];
  assign normal_x_o = nrm_q[0];
  assign normal_y_o = nrm_q[1];
  assign normal_z_o = nrm_q[2];
  assign atlas_u_o = k_q[0] ? at_q[1] : at_q[0];
  assign atlas_v_o = k_q[1] ? at_q[3] : at_q[2];
  assign last_o = (k_q == 2'd3);
endmodule

@@ rtl/core/tqvg_divsqrt.sv @@
// Shared bit-serial unsigned divider and integer square root.
// Depends on tqvg_pkg. One quotient or root bit per cycle.
`timescale 1ns / 1ps
module tqvg_divsqrt import tqvg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic        busy_q, busy_d, sq_q, sq_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] num_q, num_d, quo_q, quo_d;
  logic [63:0] rem_q, rem_d;
  logic [47:0] den_q, den_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [63:0] rs;

  always_comb begin
    busy_d = busy_q; sq_d = sq_q; cnt_d = cnt_q; num_d = num_q; quo_d = quo_q;
    rem_d = rem_q; den_d = den_q; done_d = 1'b0;
    trial = '0; rs = '0;
    if (req_i.start) begin
      busy_d = 1'b1; sq_d = req_i.is_sqrt; num_d = req_i.num; den_d = req_i.den;
      quo_d = '0; rem_d = '0;
      cnt_d = req_i.is_sqrt ? 7'd32 : 7'd64;
    end else if (busy_q) begin
      if (sq_q) begin
        // restoring root: take two bits of radicand per step
        rs = {rem_q[61:0], num_q[63:62]};
        trial = {1'b0, rs} - {1'b0, quo_q[61:0], 2'b01};
        num_d = {num_q[61:0], 2'b00};
        if (!trial[64]) begin
          rem_d = trial[63:0]; quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rs; quo_d = {quo_q[62:0], 1'b0};
        end
      end else begin
        rs = {rem_q[62:0], num_q[63]};
        trial = {1'b0, rs} - {17'd0, den_q};
        num_d = {num_q[62:0], 1'b0};
        if (!trial[64]) begin
          rem_d = trial[63:0]; quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rs; quo_d = {quo_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; sq_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; sq_q <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q[47:0];
endmodule

@@ rtl/core/tqvg_checker.sv @@
// Port-level checker for the terrain quad vertex generator, with its bind.
// Depends on terrain_quad_vertex_generator_defines.svh.
`timescale 1ns / 1ps
`include "terrain_quad_vertex_generator_defines.svh"
module tqvg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic        last_o,
  input logic [15:0] vertex_index_o
);
  `TQV_ASSERT_NXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(vertex_index_o))
  `TQV_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, valid_o, stall_o)
  `TQV_ASSERT_IMP(a_last_idx, clk_i, rst_ni, valid_o, last_o == (vertex_index_o[1:0] == 2'd3))
  `TQV_ASSERT_NXT(a_next_idx, clk_i, rst_ni, valid_o && !stall_i && !last_o, valid_o && vertex_index_o == $past(vertex_index_o) + 16'd1)
  `TQV_ASSERT_NXT(a_in_busy, clk_i, rst_ni, valid_i && !stall_o, stall_o)
endmodule

bind terrain_quad_vertex_generator tqvg_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
  .valid_o(valid_o), .stall_i(stall_i), .last_o(last_o), .vertex_index_o(vertex_index_o)
);
